### src/wpq_pkg.sv
package wpq_pkg;

    localparam int NUM_WEIGHTS = 5;
    localparam int WEIGHT_W    = 4;
    localparam int PRIO_W      = 7;
    localparam int TAG_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int STEP_W      = 3;

    typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weight_set_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SERVE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_EYE_PAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADACHE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEVER      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHEST_PAIN = 3'd4;

    // Element 0 is flag zero; the literal lists the highest element first.
    localparam weight_set_t WEIGHT_RESET = {4'd10, 4'd1, 4'd4, 4'd2, 4'd3};

endpackage

### src/wpq_if.sv
interface wpq_in_if
    import wpq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [TAG_W-1:0]  entry_tag;
    logic              flag_eye_pain;
    logic              flag_headache;
    logic              flag_fever;
    logic              flag_cough;
    logic              flag_chest_pain;

    modport source (
        output valid, opcode, entry_tag, flag_eye_pain, flag_headache, flag_fever,
               flag_cough, flag_chest_pain,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_tag, flag_eye_pain, flag_headache, flag_fever,
               flag_cough, flag_chest_pain,
        output ready
    );
endinterface

interface wpq_out_if
    import wpq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    result_tag;
    logic [PRIO_W-1:0]   result_priority;
    logic [OCC_W-1:0]    occupancy;

    modport source (
        output valid, status, result_tag, result_priority, occupancy,
        input  ready
    );
    modport sink (
        input  valid, status, result_tag, result_priority, occupancy,
        output ready
    );
endinterface

### src/weighted_priority_queue.sv
// Channel   Role     Payload
// cmd       sink     opcode, entry_tag, five flag bits
// rsp       source   status, result_tag, result_priority, occupancy
// cfg_*     write    cfg_write_en, cfg_index, cfg_data (one weight per write)
//
// One request at a time: a single adder sums the priority, one flag weight at a time, after accept.
// Then a serve reads the head entry from the RAM, an empty serve or a full insert answers without
// touching the RAM, and an insert walks from the tail toward the head, moving one entry per step
// until a compare stops it or it reaches the head slot; the entry RAM has one read and one write port.
// Reset clears the count and the head pointer and loads the default weights; the RAM is not cleared.
// A result waiting on rsp.ready does not block acceptance; a second one waits in place.
module weighted_priority_queue
    import wpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    wpq_in_if.sink               cmd,
    wpq_out_if.source            rsp,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WEIGHT_W-1:0]  cfg_data
);

    localparam int AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = TAG_BITS + PRIO_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DECIDE,
        S_HEAD_WAIT,
        S_WALK,
        S_CMP,
        S_FINISH
    } state_t;

    weight_set_t weights;

    state_t                   state_reg,      state_next;
    logic                     opcode_reg,     opcode_next;
    logic [TAG_BITS-1:0]      tag_reg,        tag_next;
    logic [NUM_WEIGHTS-1:0]   flags_reg,      flags_next;
    logic [STEP_W-1:0]        step_reg,       step_next;
    logic [PRIO_W-1:0]        prio_reg,       prio_next;
    logic [AW-1:0]            head_reg,       head_next;
    logic [CW-1:0]            count_reg,      count_next;
    logic [AW-1:0]            wr_ptr_reg,     wr_ptr_next;
    logic [CW-1:0]            pos_reg,        pos_next;
    status_t                  res_status_reg, res_status_next;
    logic [TAG_BITS-1:0]      res_tag_reg,    res_tag_next;
    logic [PRIO_W-1:0]        res_prio_reg,   res_prio_next;
    logic                     out_valid_reg,  out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic [TAG_W-1:0]         out_tag_reg,    out_tag_next;
    logic [PRIO_W-1:0]        out_prio_reg,   out_prio_next;
    logic [OCC_W-1:0]         out_occ_reg,    out_occ_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [ENTRY_W-1:0]       ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic [PRIO_W-1:0]        rd_prio;
    logic [TAG_BITS-1:0]      rd_tag;
    logic [AW-1:0]            prev_ptr;
    logic [AW-1:0]            head_inc;
    logic [AW:0]              tail_sum;
    logic [AW-1:0]            tail_ptr;
    logic [PRIO_W-1:0]        addend;

    wpq_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .weights      (weights)
    );

    wpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_prio = ram_rdata[PRIO_W-1:0];
    assign rd_tag  = ram_rdata[ENTRY_W-1:PRIO_W];

    // The queue is a ring: logical slot i lives at (head + i) wrapped to the depth.
    assign prev_ptr = (wr_ptr_reg == '0) ? AW'(QUEUE_DEPTH - 1) : wr_ptr_reg - 1'b1;
    assign head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum = {1'b0, head_reg} + (AW+1)'(count_reg);
    assign tail_ptr = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                      AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);

    assign addend = flags_reg[step_reg] ? PRIO_W'(weights[step_reg]) : '0;

    assign cmd.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.result_tag      = out_tag_reg;
    assign rsp.result_priority = out_prio_reg;
    assign rsp.occupancy       = out_occ_reg;

    always_comb
    begin
        state_next      = state_reg;
        opcode_next     = opcode_reg;
        tag_next        = tag_reg;
        flags_next      = flags_reg;
        step_next       = step_reg;
        prio_next       = prio_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        wr_ptr_next     = wr_ptr_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_prio_next   = res_prio_reg;
        out_valid_next  = out_valid_reg & ~rsp.ready;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_prio_next   = out_prio_reg;
        out_occ_next    = out_occ_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_ptr_reg;
        ram_wdata       = {tag_reg, prio_reg};
        ram_raddr       = (state_reg == S_DECIDE) ? head_reg : prev_ptr;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    opcode_next = cmd.opcode;
                    tag_next    = TAG_BITS'(cmd.entry_tag);
                    flags_next  = {cmd.flag_chest_pain, cmd.flag_cough, cmd.flag_fever,
                                   cmd.flag_headache, cmd.flag_eye_pain};
                    step_next   = '0;
                    prio_next   = '0;
                    state_next  = S_SUM;
                end
            end
            S_SUM:
            begin
                prio_next = prio_reg + addend;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_WEIGHTS - 1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (opcode_reg == OP_SERVE)
                begin
                    if (count_reg == '0)
                    begin
                        res_status_next = STATUS_EMPTY;
                        res_tag_next    = '0;
                        res_prio_next   = '0;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_HEAD_WAIT;
                    end
                end
                else if (count_reg == CW'(QUEUE_DEPTH))
                begin
                    res_status_next = STATUS_FULL;
                    res_tag_next    = '0;
                    res_prio_next   = prio_reg;
                    state_next      = S_FINISH;
                end
                else
                begin
                    wr_ptr_next = tail_ptr;
                    pos_next    = count_reg;
                    state_next  = S_WALK;
                end
            end
            S_HEAD_WAIT:
            begin
                res_status_next = STATUS_DONE;
                res_tag_next    = rd_tag;
                res_prio_next   = rd_prio;
                head_next       = head_inc;
                count_next      = count_reg - 1'b1;
                state_next      = S_FINISH;
            end
            S_WALK:
            begin
                // At the head slot the new entry lands without a compare.
                if (pos_reg == '0)
                begin
                    ram_we          = 1'b1;
                    count_next      = count_reg + 1'b1;
                    res_status_next = STATUS_DONE;
                    res_tag_next    = tag_reg;
                    res_prio_next   = prio_reg;
                    state_next      = S_FINISH;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ram_we = 1'b1;
                if (rd_prio > prio_reg)
                begin
                    count_next      = count_reg + 1'b1;
                    res_status_next = STATUS_DONE;
                    res_tag_next    = tag_reg;
                    res_prio_next   = prio_reg;
                    state_next      = S_FINISH;
                end
                else
                begin
                    // Equal or lower priority moves one slot toward the tail.
                    ram_wdata   = ram_rdata;
                    wr_ptr_next = prev_ptr;
                    pos_next    = pos_reg - 1'b1;
                    state_next  = S_WALK;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_tag_next    = TAG_W'(res_tag_reg);
                    out_prio_next   = res_prio_reg;
                    out_occ_next    = OCC_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            opcode_reg     <= OP_INSERT;
            tag_reg        <= '0;
            flags_reg      <= '0;
            step_reg       <= '0;
            prio_reg       <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            wr_ptr_reg     <= '0;
            pos_reg        <= '0;
            res_status_reg <= STATUS_DONE;
            res_tag_reg    <= '0;
            res_prio_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_DONE;
            out_tag_reg    <= '0;
            out_prio_reg   <= '0;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            opcode_reg     <= opcode_next;
            tag_reg        <= tag_next;
            flags_reg      <= flags_next;
            step_reg       <= step_next;
            prio_reg       <= prio_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            wr_ptr_reg     <= wr_ptr_next;
            pos_reg        <= pos_next;
            res_status_reg <= res_status_next;
            res_tag_reg    <= res_tag_next;
            res_prio_reg   <= res_prio_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_tag_reg    <= out_tag_next;
            out_prio_reg   <= out_prio_next;
            out_occ_reg    <= out_occ_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_ram_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_WALK || state_reg == S_CMP))
        else $error("entry RAM written outside the insert walk");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_next != count_reg) |->
            (state_reg == S_HEAD_WAIT || state_reg == S_WALK || state_reg == S_CMP))
        else $error("entry count changed outside serve or insert");

    a_accept_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == S_SUM && step_reg == '0))
        else $error("accepted request did not start the priority sum");

    a_walk_position: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (pos_reg <= count_reg))
        else $error("insert position beyond stored entries");
`endif

endmodule

### src/wpq_ram.sv
module wpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/wpq_cfg.sv
module wpq_cfg
    import wpq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WEIGHT_W-1:0]  cfg_data,
    output weight_set_t          weights
);

    weight_set_t weights_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg <= WEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_EYE_PAIN:   weights_reg[0] <= cfg_data;
                REG_HEADACHE:   weights_reg[1] <= cfg_data;
                REG_FEVER:      weights_reg[2] <= cfg_data;
                REG_COUGH:      weights_reg[3] <= cfg_data;
                REG_CHEST_PAIN: weights_reg[4] <= cfg_data;
                default:        weights_reg <= weights_reg;
            endcase
        end
    end

    assign weights = weights_reg;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import wpq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int DRAIN_SETTLE_CYCLES = 8 + 2 * QUEUE_DEPTH + 24;

    typedef struct packed {
        status_t           status;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occ;
    } wpq_result_t;

    typedef struct packed {
        logic                   op;
        logic [TAG_W-1:0]       tag;
        logic [NUM_WEIGHTS-1:0] flags;
        logic                   known;
        wpq_result_t            typed;
    } directed_row_t;

    localparam wpq_result_t NO_TYPED = '{STATUS_DONE, '0, '0, '0};

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WEIGHT_W-1:0]  cfg_data;

    wpq_in_if  cmd_bus ();
    wpq_out_if rsp_bus ();

    weighted_priority_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_bus),
        .rsp          (rsp_bus),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow of the block's state: weights and the sorted entries, head at slot 0.
    weight_set_t       weight_copy = WEIGHT_RESET;
    logic [TAG_W-1:0]  held_tags  [QUEUE_DEPTH];
    logic [PRIO_W-1:0] held_prios [QUEUE_DEPTH];
    int                held_count = 0;

    wpq_result_t pending_results [$];
    int          fail_count    = 0;
    int          hold_off_left = 0;
    bit          idling_on     = 1'b1;

    // Default weights are eye 3, headache 2, fever 4, cough 1, chest 10.
    directed_row_t directed_rows [0:22] = '{
        '{OP_SERVE,  16'hFFFF, 5'b11111, 1'b1, '{STATUS_EMPTY, 16'h0000, 7'd0, 5'd0}},
        '{OP_INSERT, 16'hFFFF, 5'b11111, 1'b1, '{STATUS_DONE, 16'hFFFF, 7'd20, 5'd1}},
        '{OP_INSERT, 16'h0000, 5'b00000, 1'b1, '{STATUS_DONE, 16'h0000, 7'd0, 5'd2}},
        '{OP_INSERT, 16'h8000, 5'b10000, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'h0001, 5'b10000, 1'b0, NO_TYPED},
        '{OP_SERVE,  16'h0000, 5'b00000, 1'b0, NO_TYPED},
        '{OP_SERVE,  16'h5A5A, 5'b01010, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'h00FF, 5'b00001, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'hFF00, 5'b00010, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'h0F0F, 5'b00100, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'hF0F0, 5'b01000, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'h3333, 5'b00011, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'hCCCC, 5'b00101, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'h5555, 5'b01001, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'hAAAA, 5'b10001, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'h1234, 5'b01110, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'h4321, 5'b11000, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'h6666, 5'b00000, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'h9999, 5'b10100, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'h0002, 5'b00110, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'h8001, 5'b11111, 1'b0, NO_TYPED},
        '{OP_INSERT, 16'h7777, 5'b11111, 1'b1, '{STATUS_FULL, 16'h0000, 7'd20, 5'd16}},
        '{OP_SERVE,  16'hFFFF, 5'b11111, 1'b0, NO_TYPED}
    };

    function automatic wpq_result_t queue_model_step(input logic op,
                                                     input logic [TAG_W-1:0] tag,
                                                     input logic [NUM_WEIGHTS-1:0] flags);
        wpq_result_t       r;
        logic [PRIO_W-1:0] prio;
        int                pos;
        prio = '0;
        for (int k = 0; k < NUM_WEIGHTS; k++)
            if (flags[k])
                prio = prio + PRIO_W'(weight_copy[k]);
        r = '{STATUS_DONE, '0, '0, '0};
        if (op == OP_INSERT)
        begin
            r.prio = prio;
            if (held_count >= QUEUE_DEPTH)
                r.status = STATUS_FULL;
            else
            begin
                // The new entry passes every entry of lower or equal priority.
                pos = 0;
                while (pos < held_count && held_prios[pos] > prio)
                    pos++;
                for (int k = held_count; k > pos; k--)
                begin
                    held_tags[k]  = held_tags[k-1];
                    held_prios[k] = held_prios[k-1];
                end
                held_tags[pos]  = tag;
                held_prios[pos] = prio;
                held_count++;
                r.tag = tag;
            end
        end
        else if (held_count == 0)
            r.status = STATUS_EMPTY;
        else
        begin
            r.tag  = held_tags[0];
            r.prio = held_prios[0];
            for (int k = 1; k < held_count; k++)
            begin
                held_tags[k-1]  = held_tags[k];
                held_prios[k-1] = held_prios[k];
            end
            held_count--;
        end
        r.occ = OCC_W'(held_count);
        return r;
    endfunction

    // Called just after a rising edge; leaves valid high for the caller to keep or drop.
    task automatic offer_request(input logic op, input logic [TAG_W-1:0] tag,
                                 input logic [NUM_WEIGHTS-1:0] flags,
                                 input logic known, input wpq_result_t typed);
        wpq_result_t predicted;
        cmd_bus.valid           <= 1'b1;
        cmd_bus.opcode          <= op;
        cmd_bus.entry_tag       <= tag;
        cmd_bus.flag_eye_pain   <= flags[0];
        cmd_bus.flag_headache   <= flags[1];
        cmd_bus.flag_fever      <= flags[2];
        cmd_bus.flag_cough      <= flags[3];
        cmd_bus.flag_chest_pain <= flags[4];
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        predicted = queue_model_step(op, tag, flags);
        pending_results.push_back(known ? typed : predicted);
    endtask

    task automatic pause_sender();
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic settle_until_idle(input int extra_cycles);
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (extra_cycles) @(posedge clk);
    endtask

    // Writes all eight register slots; the slots past the weights must be ignored.
    task automatic write_weights(input weight_set_t w);
        for (int r = 0; r < (1 << CFG_IDX_W); r++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= CFG_IDX_W'(r);
            cfg_data     <= (r < NUM_WEIGHTS) ? w[r] : WEIGHT_W'($urandom);
            @(posedge clk);
            if (CFG_IDX_W'(r) <= REG_CHEST_PAIN)
                weight_copy[r] = w[r];
        end
        cfg_write_en <= 1'b0;
    endtask

    task automatic run_random_phase(input int n_requests, input int insert_pct);
        for (int i = 0; i < n_requests; i++)
        begin
            pause_sender();
            offer_request(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_SERVE,
                          TAG_W'($urandom), NUM_WEIGHTS'($urandom), 1'b0, NO_TYPED);
        end
    endtask

    initial
    begin : stimulus
        weight_set_t rand_w;
        rst_n                   <= 1'b0;
        cfg_write_en            <= 1'b0;
        cfg_index               <= '0;
        cfg_data                <= '0;
        cmd_bus.valid           <= 1'b0;
        cmd_bus.opcode          <= OP_INSERT;
        cmd_bus.entry_tag       <= '0;
        cmd_bus.flag_eye_pain   <= 1'b0;
        cmd_bus.flag_headache   <= 1'b0;
        cmd_bus.flag_fever      <= 1'b0;
        cmd_bus.flag_cough      <= 1'b0;
        cmd_bus.flag_chest_pain <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            pause_sender();
            offer_request(directed_rows[i].op, directed_rows[i].tag, directed_rows[i].flags,
                          directed_rows[i].known, directed_rows[i].typed);
        end
        settle_until_idle(4);

        // Every weight at its maximum, with a long response stall in the middle.
        write_weights({NUM_WEIGHTS{4'hF}});
        run_random_phase(20, 75);
        hold_off_left = 300;
        run_random_phase(80, 75);
        settle_until_idle(4);

        // All weights zero: every entry ties, so service is newest first.
        write_weights('0);
        run_random_phase(80, 50);
        settle_until_idle(4);

        rand_w = weight_set_t'($urandom);
        write_weights(rand_w);
        run_random_phase(100, 30);
        settle_until_idle(4);

        rand_w = weight_set_t'($urandom);
        write_weights(rand_w);
        run_random_phase(100, 65);
        settle_until_idle(4);

        rand_w = weight_set_t'($urandom);
        write_weights(rand_w);
        idling_on = 1'b0;
        run_random_phase(120, 50);
        settle_until_idle(DRAIN_SETTLE_CYCLES);

        if (pending_results.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : response_side
        wpq_result_t oldest;
        int          gap_left;
        gap_left = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected response, status %0d tag %h prio %0d occ %0d",
                             $time, rsp_bus.status, rsp_bus.result_tag,
                             rsp_bus.result_priority, rsp_bus.occupancy);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (rsp_bus.status !== oldest.status ||
                        rsp_bus.result_tag !== oldest.tag ||
                        rsp_bus.result_priority !== oldest.prio ||
                        rsp_bus.occupancy !== oldest.occ)
                    begin
                        // Fields in order: status, tag, priority, occupancy.
                        $display("%0t: mismatch, expected %0d/%h/%0d/%0d, actual %0d/%h/%0d/%0d",
                                 $time, oldest.status, oldest.tag, oldest.prio, oldest.occ,
                                 rsp_bus.status, rsp_bus.result_tag,
                                 rsp_bus.result_priority, rsp_bus.occupancy);
                        fail_count++;
                    end
                end
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(1, 15) - 1;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
